/* sv/resp_command_deframer_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the command deframer
// Simulation-only concurrent checks on the local clk and rst; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef RESP_COMMAND_DEFRAMER_CORE_ASSERT_SVH
`define RESP_COMMAND_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define RCD_ASSERT_HOLD(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define RCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RCD_ASSERT_HOLD(lbl, ante, cons, msg)
`define RCD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* sv/rcd_pkg.sv */
// ---------------------------------------------------------------------------
// rcd_pkg
// Shared types and constants of the command deframer.
// ---------------------------------------------------------------------------
package rcd_pkg;

  localparam int BYTE_W       = 8;
  localparam int PART_INDEX_W = 10;
  localparam int ERROR_W      = 2;
  localparam int CFG_INDEX_W  = 1;

  // Error codes
  localparam logic [ERROR_W-1:0] ERR_NONE   = 2'd0;
  localparam logic [ERROR_W-1:0] ERR_HEADER = 2'd1;
  localparam logic [ERROR_W-1:0] ERR_NUMBER = 2'd2;
  localparam logic [ERROR_W-1:0] ERR_LIMIT  = 2'd3;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PART_COUNT  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PART_LENGTH = 1'd1;

  // Characters
  localparam logic [BYTE_W-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  // Bytes skipped after each part's data
  localparam logic [1:0] TRAILER_LEN = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0]       data_byte;
    logic [PART_INDEX_W-1:0] part_index;
    logic                    part_empty;
    logic                    last_of_part;
    logic                    last_of_command;
    logic [ERROR_W-1:0]      error_code;
  } rcd_result_t;

  typedef struct packed {
    logic        valid;
    rcd_result_t result;
  } rcd_beat_t;

endpackage

/* sv/rcd_channels.sv */
// ---------------------------------------------------------------------------
// Command deframer channels
// Byte input channel and result output channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface rcd_byte_if import rcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface rcd_result_if import rcd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [BYTE_W-1:0]       data_byte;
  logic [PART_INDEX_W-1:0] part_index;
  logic                    part_empty;
  logic                    last_of_part;
  logic                    last_of_command;
  logic [ERROR_W-1:0]      error_code;

  modport source (output valid, output data_byte, output part_index, output part_empty,
                  output last_of_part, output last_of_command, output error_code,
                  input ready);
  modport sink (input valid, input data_byte, input part_index, input part_empty,
                input last_of_part, input last_of_command, input error_code,
                output ready);
endinterface

/* sv/rcd_parser.sv */
// ---------------------------------------------------------------------------
// rcd_parser
// Framing state machine: header, count line, per-part length line, data and
// trailer. Consumes one byte per accepted beat and emits at most one result.
// ---------------------------------------------------------------------------
`include "resp_command_deframer_core_assert.svh"

module rcd_parser import rcd_pkg::*; #(
  parameter int unsigned LENGTH_WIDTH = 24,
  parameter int unsigned COUNT_WIDTH  = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [BYTE_W-1:0]       in_byte,
  input  logic [COUNT_WIDTH-1:0]  max_part_count,
  input  logic [LENGTH_WIDTH-1:0] max_part_length,
  output rcd_beat_t               beat
);

  localparam int ACC_W = ((LENGTH_WIDTH > COUNT_WIDTH) ? LENGTH_WIDTH : COUNT_WIDTH) + 1;
  localparam int MUL_W = ACC_W + 4;
  localparam logic [ACC_W-1:0] ACC_CAP = {1'b1, {(ACC_W-1){1'b0}}};

  // Phase codes; each number line has lead, sign, digit and tail sub-phases
  localparam logic [3:0] PH_HDR      = 4'd0;
  localparam logic [3:0] PH_CNT_LEAD = 4'd1;
  localparam logic [3:0] PH_CNT_SIGN = 4'd2;
  localparam logic [3:0] PH_CNT_DIG  = 4'd3;
  localparam logic [3:0] PH_CNT_TAIL = 4'd4;
  localparam logic [3:0] PH_DOLLAR   = 4'd5;
  localparam logic [3:0] PH_LEN_LEAD = 4'd6;
  localparam logic [3:0] PH_LEN_SIGN = 4'd7;
  localparam logic [3:0] PH_LEN_DIG  = 4'd8;
  localparam logic [3:0] PH_LEN_TAIL = 4'd9;
  localparam logic [3:0] PH_DATA     = 4'd10;
  localparam logic [3:0] PH_TRAILER  = 4'd11;
  localparam logic [3:0] PH_DEAD     = 4'd12;

  localparam logic [1:0] SUB_LEAD = 2'd0;
  localparam logic [1:0] SUB_SIGN = 2'd1;
  localparam logic [1:0] SUB_DIG  = 2'd2;
  localparam logic [1:0] SUB_TAIL = 2'd3;

  logic [3:0]              phase, phase_next;
  logic [ACC_W-1:0]        number_accum, number_accum_next;
  logic                    number_negative, number_negative_next;
  logic                    digit_seen, digit_seen_next;
  logic                    cr_pending, cr_pending_next;
  logic [COUNT_WIDTH-1:0]  parts_left, parts_left_next;
  logic [COUNT_WIDTH-1:0]  current_part, current_part_next;
  logic [LENGTH_WIDTH-1:0] bytes_left, bytes_left_next;
  logic [1:0]              trailer_left, trailer_left_next;

  logic                    len_line;
  logic [3:0]              line_base;
  logic [1:0]              sub;
  logic                    is_digit;
  logic [3:0]              digit_val;
  logic [MUL_W-1:0]        acc_mul;
  logic [ACC_W-1:0]        acc_sat;
  logic [COUNT_WIDTH-1:0]  parts_dec;
  logic [LENGTH_WIDTH-1:0] bytes_dec;
  logic [1:0]              trailer_dec;

  // Decode the number line sub-phase and the digit accumulate path
  assign len_line  = (phase >= PH_LEN_LEAD);
  assign line_base = len_line ? PH_LEN_LEAD : PH_CNT_LEAD;
  assign sub       = 2'(phase - line_base);
  assign is_digit  = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
  assign digit_val = 4'(in_byte - CHAR_ZERO);
  assign acc_mul   = (MUL_W'(number_accum) << 3) + (MUL_W'(number_accum) << 1)
                   + MUL_W'(digit_val);
  assign acc_sat   = (acc_mul > MUL_W'(ACC_CAP)) ? ACC_CAP : acc_mul[ACC_W-1:0];
  assign parts_dec   = parts_left - 1'b1;
  assign bytes_dec   = bytes_left - 1'b1;
  assign trailer_dec = trailer_left - 1'b1;

  // Next state and result for the accepted byte
  always_comb begin
    phase_next           = phase;
    number_accum_next    = number_accum;
    number_negative_next = number_negative;
    digit_seen_next      = digit_seen;
    cr_pending_next      = cr_pending;
    parts_left_next      = parts_left;
    current_part_next    = current_part;
    bytes_left_next      = bytes_left;
    trailer_left_next    = trailer_left;

    beat                   = '0;
    beat.result.part_index = PART_INDEX_W'(current_part);

    if (accept) begin
      case (phase)
        PH_HDR: begin
          if (in_byte != CHAR_STAR) begin
            phase_next                  = PH_DEAD;
            beat.valid                  = 1'b1;
            beat.result.last_of_command = 1'b1;
            beat.result.error_code      = ERR_HEADER;
          end else begin
            phase_next           = PH_CNT_LEAD;
            number_accum_next    = '0;
            number_negative_next = 1'b0;
            digit_seen_next      = 1'b0;
            cr_pending_next      = 1'b0;
          end
        end

        PH_CNT_LEAD, PH_CNT_SIGN, PH_CNT_DIG, PH_CNT_TAIL,
        PH_LEN_LEAD, PH_LEN_SIGN, PH_LEN_DIG, PH_LEN_TAIL: begin
          if (cr_pending && (in_byte == CHAR_LF)) begin
            // End of line: validate the number
            cr_pending_next = 1'b0;
            if (!digit_seen) begin
              phase_next                  = PH_DEAD;
              beat.valid                  = 1'b1;
              beat.result.last_of_command = 1'b1;
              beat.result.error_code      = ERR_NUMBER;
            end else if (!len_line) begin
              if (number_negative || (number_accum == '0)) begin
                phase_next = PH_HDR;
              end else if (number_accum > ACC_W'(max_part_count)) begin
                phase_next                  = PH_DEAD;
                beat.valid                  = 1'b1;
                beat.result.last_of_command = 1'b1;
                beat.result.error_code      = ERR_LIMIT;
              end else begin
                parts_left_next   = number_accum[COUNT_WIDTH-1:0];
                current_part_next = '0;
                phase_next        = PH_DOLLAR;
              end
            end else if (number_negative && (number_accum != '0)) begin
              phase_next                  = PH_DEAD;
              beat.valid                  = 1'b1;
              beat.result.last_of_command = 1'b1;
              beat.result.error_code      = ERR_NUMBER;
            end else if (number_accum > ACC_W'(max_part_length)) begin
              phase_next                  = PH_DEAD;
              beat.valid                  = 1'b1;
              beat.result.last_of_command = 1'b1;
              beat.result.error_code      = ERR_LIMIT;
            end else if (number_accum == '0) begin
              // Empty part: marker now, trailer still follows
              parts_left_next             = parts_dec;
              trailer_left_next           = TRAILER_LEN;
              phase_next                  = PH_TRAILER;
              beat.valid                  = 1'b1;
              beat.result.part_empty      = 1'b1;
              beat.result.last_of_part    = 1'b1;
              beat.result.last_of_command = (parts_dec == '0);
            end else begin
              bytes_left_next = number_accum[LENGTH_WIDTH-1:0];
              phase_next      = PH_DATA;
            end
          end else begin
            cr_pending_next = (in_byte == CHAR_CR);
            if (cr_pending) begin
              // A lone CR ends the number
              phase_next = line_base + {2'b00, SUB_TAIL};
            end else if (in_byte != CHAR_CR) begin
              if ((sub == SUB_LEAD) && (in_byte == CHAR_SPACE)) begin
                phase_next = phase;
              end else if ((sub == SUB_LEAD) &&
                           ((in_byte == CHAR_PLUS) || (in_byte == CHAR_MINUS))) begin
                number_negative_next = (in_byte == CHAR_MINUS);
                phase_next           = line_base + {2'b00, SUB_SIGN};
              end else if ((sub != SUB_TAIL) && is_digit) begin
                number_accum_next = acc_sat;
                digit_seen_next   = 1'b1;
                phase_next        = line_base + {2'b00, SUB_DIG};
              end else begin
                phase_next = line_base + {2'b00, SUB_TAIL};
              end
            end
          end
        end

        PH_DOLLAR: begin
          phase_next           = PH_LEN_LEAD;
          number_accum_next    = '0;
          number_negative_next = 1'b0;
          digit_seen_next      = 1'b0;
          cr_pending_next      = 1'b0;
        end

        PH_DATA: begin
          bytes_left_next       = bytes_dec;
          beat.valid            = 1'b1;
          beat.result.data_byte = in_byte;
          if (bytes_dec == '0) begin
            parts_left_next             = parts_dec;
            trailer_left_next           = TRAILER_LEN;
            phase_next                  = PH_TRAILER;
            beat.result.last_of_part    = 1'b1;
            beat.result.last_of_command = (parts_dec == '0);
          end
        end

        PH_TRAILER: begin
          trailer_left_next = trailer_dec;
          if (trailer_dec == '0) begin
            if (parts_left == '0) begin
              phase_next = PH_HDR;
            end else begin
              current_part_next = current_part + 1'b1;
              phase_next        = PH_DOLLAR;
            end
          end
        end

        default: begin
          phase_next = PH_DEAD;
        end
      endcase
    end
  end

  // Hold parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR;
      number_accum    <= '0;
      number_negative <= 1'b0;
      digit_seen      <= 1'b0;
      cr_pending      <= 1'b0;
      parts_left      <= '0;
      current_part    <= '0;
      bytes_left      <= '0;
      trailer_left    <= '0;
    end else begin
      phase           <= phase_next;
      number_accum    <= number_accum_next;
      number_negative <= number_negative_next;
      digit_seen      <= digit_seen_next;
      cr_pending      <= cr_pending_next;
      parts_left      <= parts_left_next;
      current_part    <= current_part_next;
      bytes_left      <= bytes_left_next;
      trailer_left    <= trailer_left_next;
    end
  end

  `RCD_ASSERT_NEXT(a_error_is_fatal, beat.valid && (beat.result.error_code != ERR_NONE), phase == PH_DEAD, "error result did not stop the parser")
  `RCD_ASSERT_HOLD(a_dead_is_silent, phase == PH_DEAD, !beat.valid, "result emitted after a fatal error")
  `RCD_ASSERT_NEXT(a_part_end_trailer, beat.valid && beat.result.last_of_part, (phase == PH_TRAILER) && (trailer_left == TRAILER_LEN), "part end not followed by its trailer")

endmodule

/* sv/rcd_out_buf.sv */
// ---------------------------------------------------------------------------
// rcd_out_buf
// Two-entry output buffer: result register plus skid register, so the
// parser keeps taking bytes while one result waits downstream.
// ---------------------------------------------------------------------------
`include "resp_command_deframer_core_assert.svh"

module rcd_out_buf import rcd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  rcd_beat_t    beat,
  output logic         space,
  rcd_result_if.source results
);

  logic        main_valid;
  logic        skid_valid;
  rcd_result_t main_data;
  rcd_result_t skid_data;
  logic        pop;

  assign pop   = main_valid && results.ready;
  assign space = !skid_valid;

  // Advance valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (beat.valid) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  // Move payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (beat.valid) begin
      if (!main_valid || pop) begin
        main_data <= beat.result;
      end else begin
        skid_data <= beat.result;
      end
    end
  end

  assign results.valid           = main_valid;
  assign results.data_byte       = main_data.data_byte;
  assign results.part_index      = main_data.part_index;
  assign results.part_empty      = main_data.part_empty;
  assign results.last_of_part    = main_data.last_of_part;
  assign results.last_of_command = main_data.last_of_command;
  assign results.error_code      = main_data.error_code;

  `RCD_ASSERT_HOLD(a_skid_behind_main, skid_valid, main_valid, "skid entry held with empty result register")
  `RCD_ASSERT_HOLD(a_no_push_when_full, beat.valid, !skid_valid, "result pushed into a full buffer")

endmodule

/* sv/resp_command_deframer_core.sv */
// ---------------------------------------------------------------------------
// resp_command_deframer_core
// Streaming deframer for commands sent as an array of length-prefixed parts.
// ---------------------------------------------------------------------------
// The block takes one byte per clock cycle while input ready is high, with no
// bubbles between bytes or commands: the whole framing state update for a byte
// is combinational, and the rate of one byte per cycle is set by the parse
// loop (digit accumulate by ten, saturate, compare to the limit). A result is
// registered in the result register, or in the skid register while one waits.
// A two-entry output buffer lets one more byte in while a result waits;
// input ready drops only when both entries are full. Each data byte comes out
// with its part index and last-of-part and last-of-command flags; an empty
// part gives one marker. A framing fault gives one error result, after which
// all input is drained and ignored until reset. There is no clearing pass
// after reset. Write the two limit registers only while the block is idle.
// ---------------------------------------------------------------------------
module resp_command_deframer_core import rcd_pkg::*; #(
  parameter int unsigned LENGTH_WIDTH = 24,
  parameter int unsigned COUNT_WIDTH  = 10,
  localparam int CFG_W = (LENGTH_WIDTH > COUNT_WIDTH) ? LENGTH_WIDTH : COUNT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  rcd_byte_if.sink               bytes,
  rcd_result_if.source           results,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]       wr_data
);

  localparam logic [COUNT_WIDTH-1:0]  COUNT_RESET  = COUNT_WIDTH'(32'd64);
  localparam logic [LENGTH_WIDTH-1:0] LENGTH_RESET = LENGTH_WIDTH'(32'd1048576);

  logic [COUNT_WIDTH-1:0]  max_part_count;
  logic [LENGTH_WIDTH-1:0] max_part_length;
  logic                    space;
  logic                    accept;
  rcd_beat_t               beat;

  // Hold limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_part_count  <= COUNT_RESET;
      max_part_length <= LENGTH_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_MAX_PART_COUNT:  max_part_count  <= wr_data[COUNT_WIDTH-1:0];
        REG_MAX_PART_LENGTH: max_part_length <= wr_data[LENGTH_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign bytes.ready = space;
  assign accept      = bytes.valid && space;

  rcd_parser #(
    .LENGTH_WIDTH (LENGTH_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_parser (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .in_byte         (bytes.in_byte),
    .max_part_count  (max_part_count),
    .max_part_length (max_part_length),
    .beat            (beat)
  );

  rcd_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .beat    (beat),
    .space   (space),
    .results (results)
  );

endmodule
